>>> hw/rtl/blps_pkg.sv
// Shared types, register codes and defaults of the bit-plane line preshifter.
package blps_pkg;

  localparam int unsigned MaxLineWordsDefault = 64;

  localparam int unsigned WordW   = 16;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned LineW   = 11;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegShiftAmount = 2'd0;
  localparam logic [1:0] RegLineWidth   = 2'd1;
  localparam logic [1:0] RegFillOnes    = 2'd2;

  localparam logic [ShiftW-1:0] ShiftAmountReset = 4'd0;
  localparam logic [LineW-1:0]  LineWidthReset   = 11'd24;
  localparam logic              FillOnesReset    = 1'b0;

  typedef struct packed {
    logic [ShiftW-1:0] shift_amount;
    logic [LineW-1:0]  line_width;
    logic              fill_ones;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] shifted_word;
    logic             line_end;
  } res_t;

endpackage

>>> hw/rtl/blps_cfg_regs.sv
// APB-style configuration registers of the bit-plane line preshifter.
module blps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [blps_pkg::CfgAddrW-1:0]  paddr,
  input  logic [blps_pkg::CfgDataW-1:0]  pwdata,
  output logic [blps_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output blps_pkg::cfg_t                 cfg_o
);
  import blps_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegShiftAmount: cfg_d.shift_amount = pwdata[ShiftW-1:0];
        RegLineWidth:   cfg_d.line_width   = pwdata[LineW-1:0];
        RegFillOnes:    cfg_d.fill_ones    = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegShiftAmount: prdata = CfgDataW'(cfg_q.shift_amount);
      RegLineWidth:   prdata = CfgDataW'(cfg_q.line_width);
      RegFillOnes:    prdata = CfgDataW'(cfg_q.fill_ones);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_amount <= ShiftAmountReset;
      cfg_q.line_width   <= LineWidthReset;
      cfg_q.fill_ones    <= FillOnesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/blps_word_path.sv
// Word datapath: edge masking, line-end detection and funnel shift.
module blps_word_path #(
  parameter int unsigned MAX_LINE_WORDS = blps_pkg::MaxLineWordsDefault,
  localparam int unsigned ColW = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1
) (
  input  blps_pkg::cfg_t                 cfg_i,
  input  logic [blps_pkg::WordW-1:0]     word_i,
  input  logic [ColW-1:0]                col_i,
  input  logic [blps_pkg::WordW-1:0]     prev_i,
  input  logic                           tail_phase_i,
  output blps_pkg::res_t                 res_o,
  output logic [blps_pkg::WordW-1:0]     cur_o,
  output logic                           last_o,
  output logic                           tail_need_o
);
  import blps_pkg::*;

  localparam int unsigned PixRaw  = MAX_LINE_WORDS * 16;
  localparam logic [11:0] MaxPix  = (PixRaw > 2047) ? 12'd2047 : 12'(PixRaw);
  localparam int unsigned SW      = (ColW + 4 > 12) ? ColW + 4 : 12;
  localparam int unsigned CCW     = (ColW + 1 > 8) ? ColW + 1 : 8;

  function automatic logic [WordW-1:0] funnel(input logic [WordW-1:0] hi,
                                              input logic [WordW-1:0] lo,
                                              input logic [ShiftW-1:0] s);
    logic [2*WordW-1:0] pair;
    pair = {hi, lo} >> s;
    return pair[WordW-1:0];
  endfunction

  logic [WordW-1:0] fill, keep, cur, hi;
  logic [11:0]      w, src_sum, dst_sum;
  logic [7:0]       src_words, dst_words;
  logic [SW-1:0]    start_x, w_x, diff;
  logic [3:0]       valid_pix;
  logic             past_end, partial;

  always_comb begin
    fill = {WordW{cfg_i.fill_ones}};

    // Zero width acts as one pixel; clamp to MAX_LINE_WORDS * 16 pixels, at most 2047.
    w = (cfg_i.line_width == '0) ? 12'd1 : 12'(cfg_i.line_width);
    if (w > MaxPix) begin
      w = MaxPix;
    end

    src_sum   = w + 12'd15;
    dst_sum   = w + 12'(cfg_i.shift_amount) + 12'd15;
    src_words = src_sum[11:4];
    dst_words = dst_sum[11:4];

    start_x   = SW'({col_i, 4'b0000});
    w_x       = SW'(w);
    diff      = w_x - start_x;
    past_end  = (start_x >= w_x);
    partial   = !past_end && (diff < SW'(16));
    valid_pix = diff[3:0];
    keep      = ~(16'hFFFF >> valid_pix);

    if (past_end) begin
      cur = fill;
    end else if (partial) begin
      cur = (word_i & keep) | (fill & ~keep);
    end else begin
      cur = word_i;
    end

    hi = (col_i == '0) ? fill : prev_i;

    last_o      = (CCW'(col_i) + CCW'(1)) >= CCW'(src_words);
    tail_need_o = dst_words > src_words;
    cur_o       = cur;

    // Tail word: last masked word held in prev, fill below it.
    if (tail_phase_i) begin
      res_o.shifted_word = funnel(prev_i, fill, cfg_i.shift_amount);
      res_o.line_end     = 1'b1;
    end else begin
      res_o.shifted_word = funnel(hi, cur, cfg_i.shift_amount);
      res_o.line_end     = last_o && !tail_need_o;
    end
  end

endmodule

>>> hw/rtl/blps_out_fifo.sv
// Two-entry output queue that parts the datapath from the result channel.
module blps_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  blps_pkg::res_t  data_i,
  output logic            can_push_o,
  output logic            valid_o,
  input  logic            stall_i,
  output blps_pkg::res_t  data_o
);
  import blps_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop, push;

  assign valid_o    = (count_q != 2'd0);
  assign pop        = valid_o && !stall_i;
  assign can_push_o = (count_q != 2'd2) || pop;
  assign push       = push_i && can_push_o;
  assign data_o     = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/bitplane_line_preshifter.sv
// Top level of the bit-plane line preshifter.
//
// Shifts lines of a 1-bit plane right by shift_amount pixels (0 to 15). Send the
// source words of a line in order, first pixel in bit 15; lines follow one another
// with no gap and no separator, the line end coming from line_width. Each source
// word yields one shifted word; the last word of a line yields a second, tail word
// when the shift pushes pixels past the last source word. Pixels past line_width
// and the pixels shifted in at the line start take the fill value (zeros, or ones
// when fill_ones is set). line_end marks the last output word of every line.
// Rate: one source word per cycle while the output queue has room; a last word
// that has a tail word is held in the single input register until both of its
// results have left it. An accepted word passes through the input register,
// then the two-entry output queue. Write configuration only while the
// block is idle; a write to address 12 is ignored and reads back zero.
module bitplane_line_preshifter #(
  parameter int unsigned MAX_LINE_WORDS = blps_pkg::MaxLineWordsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [blps_pkg::CfgAddrW-1:0]  paddr,
  input  logic [blps_pkg::CfgDataW-1:0]  pwdata,
  output logic [blps_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  // Source words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [blps_pkg::WordW-1:0]     source_word_i,
  // Shifted words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [blps_pkg::WordW-1:0]     shifted_word_o,
  output logic                           line_end_o
);
  import blps_pkg::*;

  localparam int unsigned ColW = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;

  cfg_t             cfg;
  res_t             path_res, fifo_res;
  logic [WordW-1:0] cur;
  logic             last, tail_need, can_push;

  // Input register and line state
  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             tail_phase_q;
  logic [ColW-1:0]  col_q;
  logic [WordW-1:0] prev_q;

  logic push, s1_done, accept, has_tail;

  blps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  blps_word_path #(
    .MAX_LINE_WORDS (MAX_LINE_WORDS)
  ) u_path (
    .cfg_i        (cfg),
    .word_i       (s1_word_q),
    .col_i        (col_q),
    .prev_i       (prev_q),
    .tail_phase_i (tail_phase_q),
    .res_o        (path_res),
    .cur_o        (cur),
    .last_o       (last),
    .tail_need_o  (tail_need)
  );

  // A result leaves the input register whenever the output queue has room.
  assign push     = s1_valid_q && can_push;
  assign has_tail = !tail_phase_q && last && tail_need;
  assign s1_done  = push && !has_tail;

  assign in_stall_o = s1_valid_q && !s1_done;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      tail_phase_q <= 1'b0;
      col_q        <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end

      // Hold the word in the input register to emit its tail word.
      if (push && has_tail) begin
        tail_phase_q <= 1'b1;
      end else if (push) begin
        tail_phase_q <= 1'b0;
      end

      // Advance the column on the main word; drop back to zero at line end.
      if (push && !tail_phase_q) begin
        col_q <= last ? '0 : col_q + ColW'(1);
      end
    end
  end

  // prev feeds the next word's upper half and the tail word; at column zero
  // the fill value replaces it, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= source_word_i;
    end
    if (push && !tail_phase_q) begin
      prev_q <= cur;
    end
  end

  blps_out_fifo u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (path_res),
    .can_push_o (can_push),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .data_o     (fifo_res)
  );

  assign shifted_word_o = fifo_res.shifted_word;
  assign line_end_o     = fifo_res.line_end;

endmodule

>>> test/line_shift_checker.sv
// Checker for the bit-plane line preshifter: predicts shifted words and compares them.
`timescale 1ns / 100ps

module line_shift_checker #(
  parameter int unsigned MAX_LINE_WORDS = blps_pkg::MaxLineWordsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blps_pkg::CfgAddrW-1:0] paddr,
  input  logic [blps_pkg::CfgDataW-1:0] pwdata,
  input  logic                          pready,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [blps_pkg::WordW-1:0]    source_word_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [blps_pkg::WordW-1:0]    shifted_word_o,
  input  logic                          line_end_o,
  output int unsigned                   words_pending,
  output int unsigned                   error_count
);

  logic [blps_pkg::ShiftW-1:0] shift_q;
  logic [blps_pkg::LineW-1:0]  line_width_q;
  logic                        fill_ones_q;
  logic [blps_pkg::WordW-1:0]  prev_word_q;
  logic [6:0]                  column_q;

  blps_pkg::res_t expected_words[$];

  function automatic logic [15:0] funnel_bits(logic [15:0] hi, logic [15:0] lo,
                                              int unsigned s);
    logic [31:0] pair;
    pair = {hi, lo};
    return 16'(pair >> s);
  endfunction

  // Mask the word against the line width, then funnel it with the previous word.
  task automatic shift_source_word(input logic [15:0] word);
    logic [15:0] fill, cur, hi, keep;
    int unsigned w, s, src_words, dst_words, start, valid_px;
    bit last;
    blps_pkg::res_t res;
    fill = fill_ones_q ? 16'hFFFF : 16'h0000;
    w = (line_width_q == 0) ? 1 : line_width_q;
    if (w > MAX_LINE_WORDS * 16) w = MAX_LINE_WORDS * 16;
    s = shift_q;
    src_words = (w + 15) / 16;
    dst_words = (w + s + 15) / 16;
    start = column_q * 16;
    cur = word;
    hi = (column_q == 0) ? fill : prev_word_q;
    if (start >= w) begin
      cur = fill;
    end else if (w - start < 16) begin
      valid_px = w - start;
      keep = 16'hFFFF << (16 - valid_px);
      cur = (cur & keep) | (fill & ~keep);
    end
    last = (column_q + 1 >= src_words);
    res.shifted_word = funnel_bits(hi, cur, s);
    res.line_end = last && !(dst_words > src_words);
    expected_words.push_back(res);
    if (!last) begin
      prev_word_q = cur;
      column_q = column_q + 7'd1;
    end else begin
      prev_word_q = fill;
      column_q = '0;
      if (dst_words > src_words) begin
        res.shifted_word = funnel_bits(cur, fill, s);
        res.line_end = 1'b1;
        expected_words.push_back(res);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blps_pkg::res_t exp_res;
    if (!rst_ni) begin
      shift_q = blps_pkg::ShiftAmountReset;
      line_width_q = blps_pkg::LineWidthReset;
      fill_ones_q = blps_pkg::FillOnesReset;
      prev_word_q = '0;
      column_q = '0;
      expected_words.delete();
      error_count = 0;
      words_pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          blps_pkg::RegShiftAmount: shift_q = pwdata[blps_pkg::ShiftW-1:0];
          blps_pkg::RegLineWidth:   line_width_q = pwdata[blps_pkg::LineW-1:0];
          blps_pkg::RegFillOnes:    fill_ones_q = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) shift_source_word(source_word_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected shifted word %h line_end %b", $time,
                   shifted_word_o, line_end_o);
          error_count++;
        end else begin
          exp_res = expected_words.pop_front();
          if (shifted_word_o !== exp_res.shifted_word) begin
            $display("%0t: shifted_word expected %h, actual %h", $time,
                     exp_res.shifted_word, shifted_word_o);
            error_count++;
          end
          if (line_end_o !== exp_res.line_end) begin
            $display("%0t: line_end expected %b, actual %b", $time,
                     exp_res.line_end, line_end_o);
            error_count++;
          end
        end
      end
      words_pending <= expected_words.size();
    end
  end

endmodule

>>> test/bitplane_line_preshifter_tb.sv
// Testbench top for the bit-plane line preshifter: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module bitplane_line_preshifter_tb;

  localparam int unsigned MaxLineWords  = blps_pkg::MaxLineWordsDefault;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned WordTarget    = 1750;
  localparam longint      TimeoutCycles = 1500000;
  // Address 12 decodes to no register; writes there must leave the setup alone.
  localparam logic [1:0]  RegUnused     = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [blps_pkg::CfgAddrW-1:0] paddr = '0;
  logic [blps_pkg::CfgDataW-1:0] pwdata = '0;
  logic [blps_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [blps_pkg::WordW-1:0]    source_word_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [blps_pkg::WordW-1:0]    shifted_word_o;
  logic                          line_end_o;

  int unsigned words_pending;
  int unsigned error_count;
  int unsigned words_sent = 0;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;
  // High while the receiver runs a requested hold-off.
  bit hold_on = 1'b0;

  // Line width as last written, used to size bursts in whole lines.
  logic [blps_pkg::LineW-1:0] cfg_width = blps_pkg::LineWidthReset;

  bitplane_line_preshifter #(
    .MAX_LINE_WORDS (MaxLineWords)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_word_i  (source_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .shifted_word_o (shifted_word_o),
    .line_end_o     (line_end_o)
  );

  line_shift_checker #(
    .MAX_LINE_WORDS (MaxLineWords)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_word_i  (source_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .shifted_word_o (shifted_word_o),
    .line_end_o     (line_end_o),
    .words_pending  (words_pending),
    .error_count    (error_count)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: alternate runs of acceptance with stalls, mostly short, a few long.
  // A requested hold-off keeps stall high throughout, then clears the request.
  initial begin : receiver
    int unsigned run_len, stall_len;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_on = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on = 1'b0;
        hold_req = 1'b0;
      end else begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 8);
        stall_len = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 50)
                                                 : $urandom_range(0, 3);
        out_stall_i <= 1'b0;
        repeat (run_len) @(posedge clk_i);
        if (stall_len != 0) begin
          out_stall_i <= 1'b1;
          repeat (stall_len) @(posedge clk_i);
        end
      end
    end
  end

  // Run one register write: setup, then access until pready, then back to idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all three registers; junk in the unused upper bits must be dropped.
  task automatic set_config(input logic [3:0] shift, input logic [10:0] width,
                            input logic fill);
    write_reg(blps_pkg::RegShiftAmount, ($urandom & ~32'hF) | shift);
    write_reg(blps_pkg::RegLineWidth, ($urandom & ~32'h7FF) | width);
    write_reg(blps_pkg::RegFillOnes, ($urandom & ~32'h1) | fill);
    cfg_width = width;
  endtask

  // Offer one source word and hold it until the block takes the transaction.
  task automatic send_word(input logic [15:0] word);
    in_valid_i    <= 1'b1;
    source_word_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // Drop valid for a random gap: most transactions none, some short, a few long.
  task automatic idle_gap();
    int unsigned gap;
    if ($urandom_range(0, 3) != 0) return;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Stop offering, wait until every expected word has arrived, then let the
  // output queue settle so a register write lands on an idle block.
  task automatic finish_burst();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_source_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [3:0]  shift;
    logic [10:0] width;
    logic        fill;
    int unsigned eff, cols, lines, n_words, phase;
    bit          dense;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset setup: 24-pixel lines, no shift, zero fill.
    send_word(16'hFFFF);
    send_word(16'h8001);
    finish_burst();

    // Widest shift on a 2-pixel line spills into a tail word; ones fill.
    set_config(4'd15, 11'd2, 1'b1);
    send_word(16'h0000);
    send_word(16'h7FFF);
    finish_burst();

    // Widest shift on a 1-pixel line fits in one word.
    set_config(4'd15, 11'd1, 1'b0);
    send_word(16'hFFFF);
    send_word(16'h8000);
    finish_burst();

    // Zero width behaves as one pixel.
    set_config(4'd7, 11'd0, 1'b1);
    send_word(16'h0000);
    send_word(16'h1234);
    finish_burst();

    // Exactly one full word per line.
    set_config(4'd0, 11'd16, 1'b1);
    send_word(16'hFFFF);
    send_word(16'h0000);
    finish_burst();

    // One pixel past a word boundary.
    set_config(4'd3, 11'd17, 1'b0);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    finish_burst();

    // Width cut mid-line: the word at column 3 lies past 20 pixels and ends the line.
    set_config(4'd5, 11'd2047, 1'b0);
    send_word(16'hA5A5);
    send_word(16'h5A5A);
    send_word(16'hFFFF);
    finish_burst();
    write_reg(blps_pkg::RegLineWidth, 32'd20);
    cfg_width = 11'd20;
    send_word(16'hFFFF);
    finish_burst();

    // Write to the unused address must change nothing.
    write_reg(RegUnused, $urandom);
    send_word(16'hC3C3);
    send_word(16'h3C3C);
    finish_burst();

    // Partial last word with ones fill and a mid shift.
    set_config(4'd9, 11'd40, 1'b1);
    send_word(16'h0F0F);
    send_word(16'hF0F0);
    send_word(16'h0000);
    finish_burst();

    // Random phases: new setup, then mostly whole lines of random words.
    phase = 0;
    while (words_sent < WordTarget) begin
      case ($urandom_range(0, 3))
        0:       shift = 4'd0;
        1:       shift = 4'd15;
        default: shift = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 11))
        0: begin
          eff = $urandom_range(0, 5);
          width = 11'((eff < 3) ? eff : eff + 12);
        end
        1:       width = 11'd1024;
        2:       width = 11'($urandom_range(1025, 2047));
        3:       width = 11'($urandom_range(900, 1023));
        default: width = 11'($urandom_range(1, 96));
      endcase
      fill = 1'($urandom_range(0, 1));

      // Partial updates keep the line position, so some lines change mid-way.
      case ($urandom_range(0, 7))
        0:       write_reg(blps_pkg::RegShiftAmount, 32'(shift));
        1:       write_reg(blps_pkg::RegFillOnes, 32'(fill));
        2: begin
          write_reg(blps_pkg::RegLineWidth, 32'(width));
          cfg_width = width;
        end
        3: begin
          write_reg(RegUnused, $urandom);
          set_config(shift, width, fill);
        end
        default: set_config(shift, width, fill);
      endcase

      eff = (cfg_width == 0) ? 1 : cfg_width;
      if (eff > MaxLineWords * 16) eff = MaxLineWords * 16;
      cols = (eff + 15) / 16;
      lines = $urandom_range(1, (64 / cols > 1) ? 64 / cols : 1);
      n_words = lines * cols;
      if (cols > 1 && $urandom_range(0, 3) == 0) n_words += $urandom_range(1, cols - 1);

      dense = ($urandom_range(0, 3) == 0);
      // Every sixth phase: receiver holds off while words keep coming,
      // so the block fills and stalls its input.
      if (phase % 6 == 5) begin
        hold_req = 1'b1;
        dense = 1'b1;
        if (n_words < 24) n_words = 24;
        // Start offering only once the hold-off is under way.
        wait (hold_on);
      end

      repeat (n_words) begin
        send_word(pick_source_word());
        if (!dense) idle_gap();
      end
      finish_burst();
      phase++;
    end

    repeat (16) @(posedge clk_i);
    if (error_count == 0 && words_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
